[hdl/length_prefix_deframer_assert.svh]
// assertion macros shared by the deframer rtl
`ifndef LENGTH_PREFIX_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIX_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPD_ASSERT_SAME(label, clk, rst, cond, expect_cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_cond)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LPD_ASSERT_NEXT(label, clk, rst, cond, expect_cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_cond)) \
    else $error(msg);

`endif

[hdl/lpd_pkg.sv]
// types and constants of the length-prefix deframer
`timescale 1ns / 1ps

package lpd_pkg;

  // bytes in the big-endian length field
  localparam int unsigned LEN_BYTES = 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned HDR_W    = 3;
  localparam int unsigned IDX_W    = 2;

  localparam logic [LEN_W-1:0] LEN_BYTES_V = LEN_W'(LEN_BYTES);
  localparam logic [HDR_W-1:0] HDR_LAST    = HDR_W'(LEN_BYTES - 1);

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = '1;
  localparam logic [BYTE_W-1:0] REQUEST_ID_RESET  = 8'd1;
  localparam logic [BYTE_W-1:0] RESPONSE_ID_RESET = 8'd2;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_RESPONSE = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SHORT    = 2'd1,
    ERR_OVERSIZE = 2'd2
  } frame_err_t;

  typedef enum logic [IDX_W-1:0] {
    REG_REQUEST_ID  = 2'd0,
    REG_RESPONSE_ID = 2'd1,
    REG_MAX_LEN     = 2'd2
  } cfg_reg_t;

endpackage

[hdl/length_prefix_deframer.sv]
// length-prefix deframer: byte stream in, annotated bytes out
// an accepted beat is held in the input register and moves to the output register when
// that is empty or being taken; one byte per cycle unless the output stalls; one input register and one output register
// with a single pass of counter and compare logic between them
// the output register frees as it is taken, so input continues under a full output
// reset: synchronous rst clears framing state and restores ids and maximum length
`timescale 1ns / 1ps

`include "length_prefix_deframer_assert.svh"

module length_prefix_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] byte_offset
  output logic        m_axis_tlast,
  output logic [4:0]  m_axis_tuser,   // [0] frame_first, [2:1] kind, [4:3] frame_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration
  logic [lpd_pkg::BYTE_W-1:0] request_id;
  logic [lpd_pkg::BYTE_W-1:0] response_id;
  logic [lpd_pkg::LEN_W-1:0]  max_len;

  // input register
  logic                       in_valid;
  logic [lpd_pkg::BYTE_W-1:0] in_byte;

  // framing state
  logic [lpd_pkg::HDR_W-1:0] header_count, header_count_next;
  logic [lpd_pkg::LEN_W-1:0] length_accum, length_accum_next;
  logic [lpd_pkg::LEN_W-1:0] bytes_left, bytes_left_next;
  logic [lpd_pkg::LEN_W-1:0] offset_count, offset_count_next;
  lpd_pkg::kind_t            kind_held, kind_held_next;
  lpd_pkg::frame_err_t       error_held, error_held_next;

  // output register
  logic                       out_valid;
  logic [lpd_pkg::BYTE_W-1:0] out_byte;
  logic [lpd_pkg::LEN_W-1:0]  out_offset;
  logic                       out_first;
  logic                       out_last;
  lpd_pkg::kind_t             out_kind;
  lpd_pkg::frame_err_t        out_error;

  // result of the current beat
  logic [lpd_pkg::LEN_W-1:0] res_offset;
  logic                      res_first;
  logic                      res_last;
  logic [lpd_pkg::LEN_W-1:0] accum_base;
  logic [lpd_pkg::LEN_W-1:0] len_new;

  logic advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_offset, out_byte};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = {out_error, out_kind, out_first};

  always_ff @(posedge clk) begin
    if (rst) begin
      request_id  <= lpd_pkg::REQUEST_ID_RESET;
      response_id <= lpd_pkg::RESPONSE_ID_RESET;
      max_len     <= lpd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (lpd_pkg::cfg_reg_t'(cfg_index))
        lpd_pkg::REG_REQUEST_ID:  request_id  <= cfg_data[lpd_pkg::BYTE_W-1:0];
        lpd_pkg::REG_RESPONSE_ID: response_id <= cfg_data[lpd_pkg::BYTE_W-1:0];
        lpd_pkg::REG_MAX_LEN:     max_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    header_count_next = header_count;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    offset_count_next = offset_count;
    kind_held_next    = kind_held;
    error_held_next   = error_held;
    res_first         = 1'b0;
    res_last          = 1'b0;
    accum_base        = length_accum;
    len_new           = '0;
    res_offset        = offset_count;

    if (bytes_left == '0) begin
      // length field beat
      if (header_count == '0) begin
        res_first       = 1'b1;
        accum_base      = '0;
        kind_held_next  = lpd_pkg::KIND_NONE;
        error_held_next = lpd_pkg::ERR_NONE;
      end
      res_offset        = {{(lpd_pkg::LEN_W-lpd_pkg::HDR_W){1'b0}}, header_count};
      len_new           = {accum_base[lpd_pkg::LEN_W-lpd_pkg::BYTE_W-1:0], in_byte};
      length_accum_next = len_new;
      if (header_count >= lpd_pkg::HDR_LAST) begin
        header_count_next = '0;
        if (len_new < lpd_pkg::LEN_BYTES_V) begin
          // too short to hold its own length field: close the frame here
          error_held_next = lpd_pkg::ERR_SHORT;
          res_last        = 1'b1;
        end else begin
          if (len_new > max_len) error_held_next = lpd_pkg::ERR_OVERSIZE;
          bytes_left_next   = len_new - lpd_pkg::LEN_BYTES_V;
          offset_count_next = lpd_pkg::LEN_BYTES_V;
          if (len_new == lpd_pkg::LEN_BYTES_V) res_last = 1'b1;
        end
      end else begin
        header_count_next = header_count + 1'b1;
      end
    end else begin
      // body beat; the first one is the type byte
      if (offset_count == lpd_pkg::LEN_BYTES_V) begin
        if (in_byte == request_id)       kind_held_next = lpd_pkg::KIND_REQUEST;
        else if (in_byte == response_id) kind_held_next = lpd_pkg::KIND_RESPONSE;
        else                             kind_held_next = lpd_pkg::KIND_OTHER;
      end
      offset_count_next = offset_count + 1'b1;
      bytes_left_next   = bytes_left - 1'b1;
      if (bytes_left == lpd_pkg::LEN_W'(1)) res_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      header_count <= '0;
      length_accum <= '0;
      bytes_left   <= '0;
      offset_count <= '0;
      kind_held    <= lpd_pkg::KIND_NONE;
      error_held   <= lpd_pkg::ERR_NONE;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid    <= 1'b1;
        header_count <= header_count_next;
        length_accum <= length_accum_next;
        bytes_left   <= bytes_left_next;
        offset_count <= offset_count_next;
        kind_held    <= kind_held_next;
        error_held   <= error_held_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
    if (advance) begin
      out_byte   <= in_byte;
      out_offset <= res_offset;
      out_first  <= res_first;
      out_last   <= res_last;
      out_kind   <= kind_held_next;
      out_error  <= error_held_next;
    end
  end

  `LPD_ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_valid,
    "processed beat did not reach the output register")
  `LPD_ASSERT_SAME(a_body_means_no_header, clk, rst, bytes_left != '0,
    header_count == '0, "body bytes pending with a part-built length field")
  `LPD_ASSERT_SAME(a_first_at_zero, clk, rst, out_valid && out_first,
    out_offset == '0, "first byte of a frame not at offset zero")
  `LPD_ASSERT_SAME(a_kind_after_header, clk, rst,
    out_valid && (out_kind != lpd_pkg::KIND_NONE),
    out_offset >= lpd_pkg::LEN_BYTES_V, "kind set inside the length field")

endmodule

[verif/length_prefix_deframer_checker.sv]
// checker for the length-prefix deframer: predicts each output beat and compares it
`timescale 1ns / 1ps

module length_prefix_deframer_checker
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] byte_offset
  input  logic        m_axis_tlast,
  input  logic [4:0]  m_axis_tuser,   // [0] frame_first, [2:1] kind, [4:3] frame_error
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] offset;
    logic        first;
    logic        last;
    kind_t       kind;
    frame_err_t  err;
  } framed_byte_t;

  framed_byte_t framed_q[$];

  int errors = 0;
  int queued = 0;
  int compared = 0;

  assign fail_count = errors;
  assign pending    = queued;
  assign checked    = compared;

  logic [7:0]       req_id;
  logic [7:0]       resp_id;
  logic [31:0]      max_len;
  logic [HDR_W-1:0] hdr_cnt;
  logic [31:0]      len_acc;
  logic [31:0]      left;
  logic [31:0]      off_cnt;
  kind_t            kind_q;
  frame_err_t       err_q;

  function automatic kind_t class_of(input logic [7:0] t);
    if (t == req_id) return KIND_REQUEST;
    if (t == resp_id) return KIND_RESPONSE;
    return KIND_OTHER;
  endfunction

  // advances the framing state by one byte and returns its annotation
  function automatic framed_byte_t deframe_byte(input logic [7:0] b);
    framed_byte_t r;
    r = '0;
    r.data = b;
    if (left == 0) begin
      if (hdr_cnt == 0) begin
        r.first = 1'b1;
        len_acc = '0;
        kind_q  = KIND_NONE;
        err_q   = ERR_NONE;
      end
      r.offset = LEN_W'(hdr_cnt);
      len_acc  = {len_acc[23:0], b};
      if (hdr_cnt >= HDR_LAST) begin
        hdr_cnt = '0;
        if (len_acc < LEN_BYTES_V) begin
          // short length: frame closes on its own length field
          err_q  = ERR_SHORT;
          r.last = 1'b1;
        end else begin
          if (len_acc > max_len) err_q = ERR_OVERSIZE;
          left    = len_acc - LEN_BYTES_V;
          off_cnt = LEN_BYTES_V;
          if (left == 0) r.last = 1'b1;
        end
      end else begin
        hdr_cnt = hdr_cnt + 1'b1;
      end
    end else begin
      r.offset = off_cnt;
      if (off_cnt == LEN_BYTES_V) kind_q = class_of(b);
      off_cnt = off_cnt + 1;
      left    = left - 1;
      if (left == 0) r.last = 1'b1;
    end
    r.kind = kind_q;
    r.err  = err_q;
    return r;
  endfunction

  always @(posedge clk) begin
    framed_byte_t want;
    framed_byte_t got;
    if (rst) begin
      req_id  = REQUEST_ID_RESET;
      resp_id = RESPONSE_ID_RESET;
      max_len = MAX_LEN_RESET;
      hdr_cnt = '0;
      len_acc = '0;
      left    = '0;
      off_cnt = '0;
      kind_q  = KIND_NONE;
      err_q   = ERR_NONE;
      framed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_REQUEST_ID:  req_id  = cfg_data[7:0];
          REG_RESPONSE_ID: resp_id = cfg_data[7:0];
          REG_MAX_LEN:     max_len = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) framed_q.push_back(deframe_byte(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.data   = m_axis_tdata[7:0];
        got.offset = m_axis_tdata[39:8];
        got.first  = m_axis_tuser[0];
        got.last   = m_axis_tlast;
        got.kind   = kind_t'(m_axis_tuser[2:1]);
        got.err    = frame_err_t'(m_axis_tuser[4:3]);
        if (framed_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected output beat: byte %02h offset %0d", got.data, got.offset);
        end else begin
          want = framed_q.pop_front();
          compared = compared + 1;
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display({"mismatch on beat %0d: expected byte %02h offset %0d",
                        " first %0b last %0b kind %0d err %0d"},
                       compared, want.data, want.offset, want.first, want.last,
                       want.kind, want.err);
              $display("  actual byte %02h offset %0d first %0b last %0b kind %0d err %0d",
                       got.data, got.offset, got.first, got.last, got.kind, got.err);
            end
          end
        end
      end
    end
    queued = framed_q.size();
  end

endmodule

[verif/length_prefix_deframer_test.sv]
// testbench top for the length-prefix deframer: stimulus, idling mixes and verdict
`timescale 1ns / 1ps

module length_prefix_deframer_test;
  import lpd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [7:0] out_byte, [39:8] byte_offset
  logic        m_axis_tlast;
  logic [4:0]  m_axis_tuser;        // [0] frame_first, [2:1] kind, [4:3] frame_error
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;

  int send_idle = 0;
  int recv_stall = 0;
  int sent_bytes = 0;
  int msg_count = 0;
  logic [7:0] cur_req = REQUEST_ID_RESET;
  logic [7:0] cur_resp = RESPONSE_ID_RESET;

  length_prefix_deframer u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  length_prefix_deframer_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sent_bytes++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // leaves cfg_valid high so back-to-back writes need no toggle
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [7:0] req, input logic [7:0] resp,
                           input logic [31:0] max_len);
    hold_until_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_REQUEST_ID, {24'd0, req});
    write_reg(REG_RESPONSE_ID, {24'd0, resp});
    write_reg(REG_MAX_LEN, max_len);
    cfg_valid <= 1'b0;
    cur_req  = req;
    cur_resp = resp;
  endtask

  task automatic send_message(input logic [31:0] len, input logic [7:0] type_byte);
    logic [31:0] n;
    for (int i = 0; i < 4; i++) send_byte(len[31-8*i -: 8]);
    if (len > LEN_BYTES_V) begin
      send_byte(type_byte);
      for (n = LEN_BYTES_V + 1; n < len; n++) send_byte(8'($urandom));
    end
    msg_count++;
  endtask

  task automatic send_random_message();
    int pick;
    logic [31:0] len;
    logic [7:0] tb;
    pick = $urandom_range(99);
    if (pick < 8) len = $urandom_range(3, 0);
    else if (pick < 16) len = LEN_BYTES_V;
    else if (pick < 22) len = $urandom_range(64, 25);
    else len = $urandom_range(24, 5);
    pick = $urandom_range(2);
    tb = (pick == 0) ? cur_req : (pick == 1) ? cur_resp : 8'($urandom);
    send_message(len, tb);
  endtask

  task automatic run_phase(input int s_idle, input int r_stall, input logic [7:0] req,
                           input logic [7:0] resp, input logic [31:0] max_len,
                           input int nbytes);
    int start;
    int msgs;
    configure(req, resp, max_len);
    send_idle  = s_idle;
    recv_stall = r_stall;
    start = sent_bytes;
    msgs = 0;
    while (sent_bytes - start < nbytes) begin
      // drain the block completely now and then
      if (msgs == 12 || $urandom_range(99) < 2) hold_until_drained();
      send_random_message();
      msgs++;
    end
  endtask

  initial begin
    logic [7:0] same_id;
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset ids: short lengths, header-only, request, other
    send_message(32'd0, 8'h00);
    send_message(32'd2, 8'h00);
    send_message(LEN_BYTES_V, 8'h00);
    send_message(32'd5, REQUEST_ID_RESET);
    send_message(32'd5, 8'hFF);
    // equal ids with the smallest maximum: request wins, everything oversize
    configure(8'hFF, 8'hFF, LEN_BYTES_V);
    send_message(32'd5, 8'hFF);
    send_message(32'd5, 8'h00);

    run_phase(0, 0, 8'h00, 8'hFF, LEN_BYTES_V, 225);
    run_phase(46, 0, 8'($urandom), 8'($urandom), $urandom_range(40, 8), 225);
    same_id = 8'($urandom);
    run_phase(0, 46, same_id, same_id, $urandom_range(40, 8), 225);
    run_phase(38, 38, 8'($urandom), 8'($urandom), MAX_LEN_RESET, 225);

    // largest declared length equals the maximum: no error, left open at the end
    for (int i = 0; i < 4; i++) send_byte(8'hFF);
    for (int i = 0; i < 16; i++) send_byte(8'($urandom));
    msg_count++;

    s_axis_tvalid <= 1'b0;
    for (waited = 0; pending != 0 && waited < 5000; waited++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending != 0) $display("%0d expected beats never arrived", pending);

    $display("sent %0d bytes in %0d messages", sent_bytes, msg_count);
    $display("  over six register settings and four idling mixes");
    $display("%0d output beats compared, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
